@@ sv/spk_pkg.sv @@
`timescale 1ns / 1ps

package spk_pkg;

	// Word width and the two fixed rotate amounts of the Speck round.
	localparam int WORD_W = 64;
	localparam int ROT_A  = 8;
	localparam int ROT_B  = 3;

	// Default number of cipher rounds.
	localparam int DEF_NUM_ROUNDS = 32;

	// Configuration port: two 64-bit key registers at byte addresses 0 and 8.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYFWD,
		ST_ENC,
		ST_DEC
	} state_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic load;       // take the input beat and the key registers
		logic data_step;  // update the data words with the round result
		logic data_inv;   // data unit runs the inverse round
		logic key_step;   // update the key pair with the schedule result
		logic key_inv;    // schedule unit runs the inverse round
		logic finish;     // capture the round result into the output register
	} ctl_t;

endpackage

@@ sv/spk_round.sv @@
`timescale 1ns / 1ps

module spk_round
	import spk_pkg::*;
(
	input  word_t x,
	input  word_t y,
	input  word_t k,
	input  logic  inv,
	output word_t x_nxt,
	output word_t y_nxt
);

	word_t f_a;
	word_t f_y;
	word_t i_b;
	word_t i_a;
	word_t i_x;

	// Forward round: x = (ror(x,8) + y) ^ k, y = rol(y,3) ^ x.
	always_comb begin
		f_a = (((x >> ROT_A) | (x << (WORD_W - ROT_A))) + y) ^ k;
		f_y = ((y << ROT_B) | (y >> (WORD_W - ROT_B))) ^ f_a;
	end

	// Inverse round: y = ror(y ^ x, 3), x = rol((x ^ k) - y, 8).
	always_comb begin
		i_b = ((y ^ x) >> ROT_B) | ((y ^ x) << (WORD_W - ROT_B));
		i_a = (x ^ k) - i_b;
		i_x = (i_a << ROT_A) | (i_a >> (WORD_W - ROT_A));
	end

	assign x_nxt = inv ? i_x : f_a;
	assign y_nxt = inv ? i_b : f_y;

endmodule

@@ sv/spk_ctrl.sv @@
`timescale 1ns / 1ps

module spk_ctrl
	import spk_pkg::*;
#(
	parameter int NUM_ROUNDS = DEF_NUM_ROUNDS,
	parameter int RC_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            func,
	input  logic            out_free,
	output logic            in_stall,
	output ctl_t            ctl,
	output logic [RC_W-1:0] key_idx
);

	localparam logic [RC_W-1:0] LAST     = RC_W'(NUM_ROUNDS - 1);
	localparam logic [RC_W-1:0] PRE_LAST = RC_W'(NUM_ROUNDS - 2);

	state_t          state_q;
	state_t          state_d;
	logic [RC_W-1:0] cnt_q;
	logic [RC_W-1:0] cnt_d;

	// State and round counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and datapath control.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					cnt_d    = '0;
					if (!func) begin
						state_d = ST_ENC;
					end else if (NUM_ROUNDS > 1) begin
						state_d = ST_KEYFWD;
					end else begin
						state_d = ST_DEC;
					end
				end
			end
			ST_KEYFWD: begin
				// Run the schedule forward up to the last round key.
				ctl.key_step = 1'b1;
				if (cnt_q == PRE_LAST) begin
					state_d = ST_DEC;
					cnt_d   = LAST;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ENC: begin
				if (cnt_q == LAST) begin
					if (out_free) begin
						ctl.data_step = 1'b1;
						ctl.finish    = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					ctl.data_step = 1'b1;
					ctl.key_step  = 1'b1;
					cnt_d         = cnt_q + 1'b1;
				end
			end
			ST_DEC: begin
				// Inverse rounds, stepping the schedule backward alongside.
				ctl.data_inv = 1'b1;
				ctl.key_inv  = 1'b1;
				if (cnt_q == '0) begin
					if (out_free) begin
						ctl.data_step = 1'b1;
						ctl.finish    = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					ctl.data_step = 1'b1;
					ctl.key_step  = 1'b1;
					cnt_d         = cnt_q - 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// The inverse schedule step from round j back to round j-1 uses index j-1.
	assign key_idx = (state_q == ST_DEC) ? (cnt_q - 1'b1) : cnt_q;

	// An accepted encrypt beat starts at round zero.
	a_enc_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !func) |=> (state_q == ST_ENC && cnt_q == '0))
		else $error("encrypt did not start at round zero");

	// A result is captured only when the output register can take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> out_free)
		else $error("result captured over a pending beat");

	// Encryption counts rounds upward one per cycle.
	a_enc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENC && cnt_q != LAST) |=>
		(cnt_q == RC_W'($past(cnt_q) + 1'b1)))
		else $error("encrypt round counter skipped");

	// Decryption counts rounds downward one per cycle.
	a_dec_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && cnt_q != '0) |=>
		(cnt_q == RC_W'($past(cnt_q) - 1'b1)))
		else $error("decrypt round counter skipped");

endmodule

@@ sv/speck_block_cipher_top.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     func, in_word_y, in_word_x
// out      output     out_valid / out_stall   out_word_y, out_word_x
// cfg      input      APB psel/penable/pready key_word_low @0, key_word_high @8
//
// Encryption runs one ARX round per cycle from the accepted beat to the result,
// with the key schedule stepping alongside.
// Decryption first runs the schedule forward to the last round key, then
// NUM_ROUNDS inverse rounds walk it back.
// in_stall is high while an item is in progress; reset returns to idle and
// clears both keys. A stalled result holds the last round until out is free.

module speck_block_cipher_top
	import spk_pkg::*;
#(
	parameter int NUM_ROUNDS = DEF_NUM_ROUNDS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [63:0]        in_word_y,
	input  logic [63:0]        in_word_x,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        out_word_y,
	output logic [63:0]        out_word_x,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int RC_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

	word_t           key_low_q;
	word_t           key_high_q;
	word_t           x_q;
	word_t           y_q;
	word_t           ka_q;
	word_t           kb_q;
	word_t           x_nxt;
	word_t           y_nxt;
	word_t           ka_nxt;
	word_t           kb_nxt;
	word_t           out_y_q;
	word_t           out_x_q;
	logic            out_valid_q;
	logic            out_free;
	logic [RC_W-1:0] key_idx;
	word_t           key_idx_w;
	logic            cfg_wr;
	ctl_t            ctl;

	// Key registers on the APB port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_KEY_LOW) begin
				key_low_q <= pwdata;
			end else begin
				key_high_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[3] == REG_KEY_HIGH) ? key_high_q : key_low_q;

	// Sequencer.
	spk_ctrl #(
		.NUM_ROUNDS(NUM_ROUNDS),
		.RC_W      (RC_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.out_free(out_free),
		.in_stall(in_stall),
		.ctl     (ctl),
		.key_idx (key_idx)
	);

	// Data round unit, keyed by the current round key.
	spk_round u_data_rnd (
		.x    (x_q),
		.y    (y_q),
		.k    (kb_q),
		.inv  (ctl.data_inv),
		.x_nxt(x_nxt),
		.y_nxt(y_nxt)
	);

	// Key schedule round unit, keyed by the round index.
	assign key_idx_w = {{(WORD_W - RC_W){1'b0}}, key_idx};

	spk_round u_key_rnd (
		.x    (ka_q),
		.y    (kb_q),
		.k    (key_idx_w),
		.inv  (ctl.key_inv),
		.x_nxt(ka_nxt),
		.y_nxt(kb_nxt)
	);

	// Working data and key pair registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			y_q  <= in_word_y;
			x_q  <= in_word_x;
			ka_q <= key_high_q;
			kb_q <= key_low_q;
		end else begin
			if (ctl.data_step) begin
				x_q <= x_nxt;
				y_q <= y_nxt;
			end
			if (ctl.key_step) begin
				ka_q <= ka_nxt;
				kb_q <= kb_nxt;
			end
		end
	end

	// Output register: holds a result beat until the sink takes it.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_y_q <= y_nxt;
			out_x_q <= x_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_word_y = out_y_q;
	assign out_word_x = out_x_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import spk_pkg::*;

	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	// Decrypt is the slowest path: schedule forward, then walk the rounds back.
	localparam int LATENCY = 2 * DEF_NUM_ROUNDS;
	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_BLOCKS = 1250;
	localparam int PHASE_BLOCKS = 125;
	localparam int MAX_REPORTS = 60;

	localparam word_t ONES = '1;
	localparam word_t MSB = {1'b1, 63'b0};
	localparam word_t ALT = 64'h5555_5555_5555_5555;

	// Published Speck128/128 key, plaintext and ciphertext.
	localparam word_t KEY_VEC_LO = 64'h0706050403020100;
	localparam word_t KEY_VEC_HI = 64'h0f0e0d0c0b0a0908;
	localparam word_t PLAIN_Y = 64'h7469206564616d20;
	localparam word_t PLAIN_X = 64'h6c61766975716520;
	localparam word_t CIPHER_Y = 64'h7860fedf5c570d18;
	localparam word_t CIPHER_X = 64'ha65d985179783265;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		word_t y;
		word_t x;
	} block_t;

	typedef struct packed {
		word_t  key_lo;
		word_t  key_hi;
		logic   dir;
		block_t din;
		logic   typed;
		block_t dout;
	} dir_row_t;

	// Directed blocks; the key columns are written whenever they change.
	localparam dir_row_t DIR_ROWS [19] = '{
		'{'0, '0, FUNC_ENC, '{'0, '0}, 1'b0, '{'0, '0}},
		'{'0, '0, FUNC_DEC, '{'0, '0}, 1'b0, '{'0, '0}},
		'{'0, '0, FUNC_ENC, '{ONES, ONES}, 1'b0, '{'0, '0}},
		'{'0, '0, FUNC_DEC, '{ONES, ONES}, 1'b0, '{'0, '0}},
		'{'0, '0, FUNC_ENC, '{ONES, '0}, 1'b0, '{'0, '0}},
		'{'0, '0, FUNC_DEC, '{'0, ONES}, 1'b0, '{'0, '0}},
		'{'0, '0, FUNC_ENC, '{64'd1, MSB}, 1'b0, '{'0, '0}},
		'{KEY_VEC_LO, KEY_VEC_HI, FUNC_ENC, '{PLAIN_Y, PLAIN_X}, 1'b1,
			'{CIPHER_Y, CIPHER_X}},
		'{KEY_VEC_LO, KEY_VEC_HI, FUNC_DEC, '{CIPHER_Y, CIPHER_X}, 1'b1,
			'{PLAIN_Y, PLAIN_X}},
		'{KEY_VEC_LO, KEY_VEC_HI, FUNC_ENC, '{ONES, '0}, 1'b0, '{'0, '0}},
		'{ONES, ONES, FUNC_ENC, '{'0, '0}, 1'b0, '{'0, '0}},
		'{ONES, ONES, FUNC_DEC, '{ONES, ONES}, 1'b0, '{'0, '0}},
		'{ONES, ONES, FUNC_ENC, '{ALT, ~ALT}, 1'b0, '{'0, '0}},
		'{ONES, '0, FUNC_ENC, '{'0, '0}, 1'b0, '{'0, '0}},
		'{ONES, '0, FUNC_DEC, '{'0, '0}, 1'b0, '{'0, '0}},
		'{'0, ONES, FUNC_ENC, '{ONES, '0}, 1'b0, '{'0, '0}},
		'{'0, ONES, FUNC_DEC, '{'0, ONES}, 1'b0, '{'0, '0}},
		'{64'd1, MSB, FUNC_DEC, '{MSB, 64'd1}, 1'b0, '{'0, '0}},
		'{64'd1, MSB, FUNC_ENC, '{64'd1, MSB}, 1'b0, '{'0, '0}}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [63:0]        in_word_y;
	logic [63:0]        in_word_x;
	logic               out_valid;
	logic               out_stall;
	logic [63:0]        out_word_y;
	logic [63:0]        out_word_x;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Local copy of the key registers and the blocks still owed by the core.
	word_t  key_lo_q;
	word_t  key_hi_q;
	block_t expected_blocks [$];
	int     send_gap_pct;
	int     recv_stall_pct;
	int     fail_count;
	int     cycle_count;

	speck_block_cipher_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.in_word_y  (in_word_y),
		.in_word_x  (in_word_x),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word_y (out_word_y),
		.out_word_x (out_word_x),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic word_t ror(word_t v, int r);
		return (v >> r) | (v << (WORD_W - r));
	endfunction

	function automatic word_t rol(word_t v, int r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	// Full Speck128 transform of one block under the given key pair.
	function automatic block_t speck_transform(logic dir, block_t blk, word_t k_lo,
			word_t k_hi);
		word_t rk [DEF_NUM_ROUNDS];
		word_t ka;
		word_t kb;
		word_t a;
		word_t b;
		word_t y;
		word_t x;
		// Key schedule: the round function on the key pair, round index as key.
		kb = k_lo;
		ka = k_hi;
		rk[0] = kb;
		for (int i = 0; i < DEF_NUM_ROUNDS - 1; i++) begin
			ka = (ror(ka, ROT_A) + kb) ^ word_t'(i);
			kb = rol(kb, ROT_B) ^ ka;
			rk[i + 1] = kb;
		end
		y = blk.y;
		x = blk.x;
		if (dir == FUNC_ENC) begin
			for (int i = 0; i < DEF_NUM_ROUNDS; i++) begin
				x = (ror(x, ROT_A) + y) ^ rk[i];
				y = rol(y, ROT_B) ^ x;
			end
		end else begin
			for (int i = DEF_NUM_ROUNDS - 1; i >= 0; i--) begin
				b = ror(y ^ x, ROT_B);
				a = (x ^ rk[i]) - b;
				x = rol(a, ROT_A);
				y = b;
			end
		end
		return '{y: y, x: x};
	endfunction

	// Mostly full-width random words, with zero, all ones, single set bits and single clear bits mixed in.
	function automatic word_t random_word();
		case ($urandom_range(11))
			0: return '0;
			1: return ONES;
			2: return MSB >> $urandom_range(63);
			3: return ~(MSB >> $urandom_range(63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (fail_count < MAX_REPORTS)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		fail_count++;
	endtask

	// One APB write: setup phase, access phase, then idle.
	task automatic apb_write(logic reg_idx, word_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(reg_idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (reg_idx == REG_KEY_LOW)
			key_lo_q = value;
		else
			key_hi_q = value;
	endtask

	// One APB read, checked against the given expected value at the access edge.
	task automatic apb_check_read(logic reg_idx, word_t want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'(reg_idx) << 3;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			report_mismatch($sformatf("key register %0d read %h, expected %h",
				reg_idx, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write whichever key words differ, then read both back.
	task automatic set_keys(word_t lo, word_t hi);
		if (lo != key_lo_q)
			apb_write(REG_KEY_LOW, lo);
		if (hi != key_hi_q)
			apb_write(REG_KEY_HIGH, hi);
		apb_check_read(REG_KEY_LOW, key_lo_q);
		apb_check_read(REG_KEY_HIGH, key_hi_q);
	endtask

	// Drop valid, let every owed block arrive, then give the core its full latency.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Hold off new beats until the core has returned everything.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_blocks.size() != 0);
	endtask

	// Present one beat, hold it until accepted, and record the block it owes.
	task automatic send_block(logic dir, block_t blk, logic typed, block_t want);
		block_t owed;
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= dir;
		in_word_y <= blk.y;
		in_word_x <= blk.x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		owed = typed ? want : speck_transform(dir, blk, key_lo_q, key_hi_q);
		expected_blocks.push_back(owed);
	endtask

	task automatic set_idle_mode(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct = 73;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct = 0;
				recv_stall_pct = 73;
			end
			default: begin
				send_gap_pct = 21;
				recv_stall_pct = 21;
			end
		endcase
	endtask

	// Output side: random stall, and every result beat checked in order.
	always @(posedge clk) begin
		block_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("speck_block_cipher_top verification failed");
			$finish;
		end else begin
			if (arst_n && out_valid && !out_stall) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat y=%h x=%h",
						out_word_y, out_word_x));
				end else begin
					want = expected_blocks.pop_front();
					if (out_word_y !== want.y)
						report_mismatch($sformatf("out_word_y %h, expected %h",
							out_word_y, want.y));
					if (out_word_x !== want.x)
						report_mismatch($sformatf("out_word_x %h, expected %h",
							out_word_x, want.x));
				end
			end
			out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Stimulus: reset, directed table, then random phases with new keys.
	initial begin
		int     phase;
		int     sent;
		int     count;
		logic   dir;
		block_t blk;
		block_t mid;
		word_t  lo;
		word_t  hi;

		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_ENC;
		in_word_y = '0;
		in_word_x = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		key_lo_q = '0;
		key_hi_q = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		cycle_count = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both keys must come out of reset cleared.
		apb_check_read(REG_KEY_LOW, '0);
		apb_check_read(REG_KEY_HIGH, '0);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].key_lo != key_lo_q || DIR_ROWS[i].key_hi != key_hi_q) begin
				wait_idle();
				set_keys(DIR_ROWS[i].key_lo, DIR_ROWS[i].key_hi);
			end
			send_block(DIR_ROWS[i].dir, DIR_ROWS[i].din, DIR_ROWS[i].typed,
				DIR_ROWS[i].dout);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_BLOCKS) begin
			// New key setting for each phase, sometimes only one word changed.
			wait_idle();
			case ($urandom_range(5))
				0: begin
					lo = '0;
					hi = '0;
				end
				1: begin
					lo = ONES;
					hi = ONES;
				end
				2: begin
					lo = {$urandom, $urandom};
					hi = key_hi_q;
				end
				3: begin
					lo = key_lo_q;
					hi = {$urandom, $urandom};
				end
				default: begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
				end
			endcase
			set_keys(lo, hi);
			set_idle_mode(idle_mode_t'(phase % 4));

			count = 0;
			while (count < PHASE_BLOCKS) begin
				if ($urandom_range(39) == 0)
					hold_until_drained();
				dir = 1'($urandom_range(1));
				blk = '{y: random_word(), x: random_word()};
				if ($urandom_range(9) < 4) begin
					// Round trip: the second beat undoes the first.
					send_block(dir, blk, 1'b0, '0);
					mid = speck_transform(dir, blk, key_lo_q, key_hi_q);
					send_block(~dir, mid, 1'b0, '0);
					count += 2;
				end else begin
					send_block(dir, blk, 1'b0, '0);
					count++;
				end
			end
			sent += count;
			phase++;
		end

		wait_idle();
		if (fail_count == 0)
			$display("speck_block_cipher_top verification clean");
		else
			$display("speck_block_cipher_top verification failed");
		$finish;
	end

endmodule
